FILE: design/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection pipeline.
`default_nettype none

package dpb_pkg;

  localparam int MAX_IMAGE_DIM = 4096;

  localparam int PIX_W    = 12;
  localparam int COLOR_W  = 8;
  localparam int DEPTH_W  = 32;
  localparam int Z_W      = 32;
  localparam int COORD_W  = 48;
  localparam int CENTER_W = 16;
  localparam int INV_W    = 32;
  localparam int CFG_IDX_W = 3;

  localparam int IN_W  = DEPTH_W + 2 * PIX_W + 3 * COLOR_W;
  localparam int OUT_W = 2 * COORD_W + Z_W + 3 * COLOR_W;

  // Millimetre scaling: z = mm * 65 + floor((mm * 536 + 500) / 1000).
  localparam logic [22:0] MM_INT_MUL  = 23'd65;
  localparam logic [25:0] MM_FRAC_MUL = 26'd536;
  localparam logic [25:0] MM_HALF     = 26'd500;
  localparam logic [26:0] MM_RECIP    = 27'd68719477;
  localparam int          MM_RECIP_SH = 36;

  // Float exponent limits for the Q16.16 conversion.
  localparam logic [7:0] EXP_UNIT = 8'd134;
  localparam logic [7:0] EXP_SAT  = 8'd143;
  localparam logic [7:0] EXP_MIN  = 8'd110;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH_FORMAT    = 3'd0,
    REG_INVERSE_FOCAL_X = 3'd1,
    REG_INVERSE_FOCAL_Y = 3'd2,
    REG_CENTER_X        = 3'd3,
    REG_CENTER_Y        = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } offset_t;

  typedef struct packed {
    logic            float_mode;
    logic [Z_W-1:0]  float_z;
    logic [25:0]     mm_frac;
    logic [22:0]     mm_base;
  } depth_dec_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

FILE: design/dpb_decode.sv
// First pipeline stage: depth word decode, pixel checks and principal point offsets.
`default_nettype none

module dpb_decode (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       depth_format,
  input  logic [dpb_pkg::CENTER_W-1:0] center_x,
  input  logic [dpb_pkg::CENTER_W-1:0] center_y,
  input  logic [dpb_pkg::DEPTH_W-1:0]  depth_raw,
  input  logic [dpb_pkg::PIX_W-1:0]    column,
  input  logic [dpb_pkg::PIX_W-1:0]    row,
  output logic                       keep,
  output dpb_pkg::depth_dec_t        dec,
  output dpb_pkg::offset_t           off_x,
  output dpb_pkg::offset_t           off_y
);
  import dpb_pkg::*;

  function automatic offset_t pix_offset(input logic [PIX_W-1:0] pix,
                                         input logic [CENTER_W-1:0] centre);
    logic [16:0] d;
    offset_t     o;
    d = {1'b0, pix, 4'd0} - {1'b0, centre};
    o.neg = d[16];
    o.mag = d[16] ? 16'(17'd0 - d) : d[15:0];
    return o;
  endfunction

  logic [15:0]    mm;
  logic [7:0]     ex;
  logic [23:0]    sig;
  logic [3:0]     sh_l;
  logic [4:0]     sh_r;
  logic [24:0]    rnd;
  logic [24:0]    right_z;
  logic [Z_W-1:0] left_z;
  logic [Z_W-1:0] float_z;
  logic           float_bad;
  logic           mm_bad;
  logic           range_bad;

  always_comb begin
    mm      = depth_raw[15:0];
    ex      = depth_raw[30:23];
    sig     = {1'b1, depth_raw[22:0]};
    sh_l    = 4'(ex - EXP_UNIT);
    sh_r    = 5'(EXP_UNIT - ex);
    left_z  = {8'd0, sig} << sh_l;
    rnd     = 25'd1 << (sh_r - 5'd1);
    right_z = ({1'b0, sig} + rnd) >> sh_r;
    if (ex >= EXP_SAT) begin
      float_z = '1;
    end else if (ex >= EXP_UNIT) begin
      float_z = left_z;
    end else begin
      float_z = {7'd0, right_z};
    end
    float_bad = (ex == EXP_SPECIAL) || depth_raw[31] || (ex < EXP_MIN);
    mm_bad    = (mm == 16'd0);
    range_bad = ({5'd0, column} >= 17'(MAX_IMAGE_DIM)) ||
                ({5'd0, row} >= 17'(MAX_IMAGE_DIM));
    keep = !range_bad && (depth_format ? !float_bad : !mm_bad);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec.float_mode <= depth_format;
      dec.float_z    <= float_z;
      dec.mm_frac    <= 26'({10'd0, mm} * MM_FRAC_MUL) + MM_HALF;
      dec.mm_base    <= 23'({7'd0, mm} * MM_INT_MUL);
      off_x          <= pix_offset(column, center_x);
      off_y          <= pix_offset(row, center_y);
    end
  end

endmodule

`default_nettype wire

FILE: design/dpb_zconv.sv
// Second and third pipeline stages: millimetre scaling and selection of the Q16.16 depth.
`default_nettype none

module dpb_zconv (
  input  logic                       clk,
  input  logic [1:0]                 load,
  input  dpb_pkg::depth_dec_t        dec,
  output logic [dpb_pkg::Z_W-1:0]    z
);
  import dpb_pkg::*;

  logic [52:0]    prod;
  logic [15:0]    quot;
  logic [22:0]    base;
  logic           float_sel;
  logic [Z_W-1:0] float_z;

  assign prod = dec.mm_frac * MM_RECIP;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      quot      <= prod[MM_RECIP_SH+15:MM_RECIP_SH];
      base      <= dec.mm_base;
      float_sel <= dec.float_mode;
      float_z   <= dec.float_z;
    end
    if (load[1]) begin
      z <= float_sel ? float_z : ({9'd0, base} + {16'd0, quot});
    end
  end

endmodule

`default_nettype wire

FILE: design/dpb_project.sv
// Four pipeline stages that scale one pixel offset by depth and inverse focal length.
`default_nettype none

module dpb_project (
  input  logic                        clk,
  input  logic [3:0]                  load,
  input  logic [dpb_pkg::Z_W-1:0]     z,
  input  dpb_pkg::offset_t            off,
  input  logic [dpb_pkg::INV_W-1:0]   inv,
  output logic [dpb_pkg::COORD_W-1:0] coord
);
  import dpb_pkg::*;

  logic [47:0] a;
  logic [63:0] lo;
  logic [47:0] hi;
  logic [48:0] sum;
  logic [47:0] mag;
  logic        neg4;
  logic        neg5;
  logic        neg6;

  assign mag = {3'd0, sum[48:4]};

  always_ff @(posedge clk) begin
    if (load[0]) begin
      a    <= off.mag * z;
      neg4 <= off.neg;
    end
    if (load[1]) begin
      lo   <= a[31:0] * inv;
      hi   <= a[47:32] * inv;
      neg5 <= neg4;
    end
    if (load[2]) begin
      sum  <= {1'b0, hi} + {17'd0, lo[63:32]} + 49'd8;
      neg6 <= neg5;
    end
    if (load[3]) begin
      coord <= neg6 ? (48'd0 - mag) : mag;
    end
  end

endmodule

`default_nettype wire

FILE: design/depth_pixel_backprojection.sv
// Top level of the pinhole depth back-projection pipeline.
// Throughput: one pixel per cycle; every stage holds while its successor is full and stalled.
// Pixels with no usable depth or outside the image leave the pipeline with no output transfer.
// Reset clears all stage valid bits and sets every configuration register to zero.
`default_nettype none

module depth_pixel_backprojection (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // depth_raw, column, row, blue_in, green_in, red_in
  input  logic [dpb_pkg::IN_W-1:0]        s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // point_x, point_y, point_z, blue_out, green_out, red_out
  output logic [dpb_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import dpb_pkg::*;

  logic                depth_format;
  logic [INV_W-1:0]    inverse_focal_x;
  logic [INV_W-1:0]    inverse_focal_y;
  logic [CENTER_W-1:0] center_x;
  logic [CENTER_W-1:0] center_y;

  logic [7:1] valid;
  logic [8:1] rdy;

  logic       keep;
  depth_dec_t dec;
  offset_t    off_x1, off_y1, off_x2, off_y2, off_x3, off_y3;
  logic [Z_W-1:0] z3;
  logic [Z_W-1:0] z_pipe [4:7];
  color_t     color_pipe [1:7];
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_format    <= 1'b0;
      inverse_focal_x <= '0;
      inverse_focal_y <= '0;
      center_x        <= '0;
      center_y        <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEPTH_FORMAT:    depth_format    <= cfg_data[0];
        REG_INVERSE_FOCAL_X: inverse_focal_x <= cfg_data;
        REG_INVERSE_FOCAL_Y: inverse_focal_y <= cfg_data;
        REG_CENTER_X:        center_x        <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:        center_y        <= cfg_data[CENTER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[8] = m_axis_tready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[1]) begin
        valid[1] <= s_axis_tvalid && keep;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  dpb_decode u_decode (
    .clk          (clk),
    .load         (rdy[1]),
    .depth_format (depth_format),
    .center_x     (center_x),
    .center_y     (center_y),
    .depth_raw    (s_axis_tdata[31:0]),
    .column       (s_axis_tdata[43:32]),
    .row          (s_axis_tdata[55:44]),
    .keep         (keep),
    .dec          (dec),
    .off_x        (off_x1),
    .off_y        (off_y1)
  );

  dpb_zconv u_zconv (
    .clk  (clk),
    .load (rdy[3:2]),
    .dec  (dec),
    .z    (z3)
  );

  dpb_project u_project_x (
    .clk   (clk),
    .load  (rdy[7:4]),
    .z     (z3),
    .off   (off_x3),
    .inv   (inverse_focal_x),
    .coord (point_x)
  );

  dpb_project u_project_y (
    .clk   (clk),
    .load  (rdy[7:4]),
    .z     (z3),
    .off   (off_y3),
    .inv   (inverse_focal_y),
    .coord (point_y)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      color_pipe[1] <= '{red:   s_axis_tdata[79:72],
                         green: s_axis_tdata[71:64],
                         blue:  s_axis_tdata[63:56]};
    end
    for (int k = 2; k <= 7; k++) begin
      if (rdy[k]) begin
        color_pipe[k] <= color_pipe[k-1];
      end
    end
    if (rdy[2]) begin
      off_x2 <= off_x1;
      off_y2 <= off_y1;
    end
    if (rdy[3]) begin
      off_x3 <= off_x2;
      off_y3 <= off_y2;
    end
    if (rdy[4]) begin
      z_pipe[4] <= z3;
    end
    for (int k = 5; k <= 7; k++) begin
      if (rdy[k]) begin
        z_pipe[k] <= z_pipe[k-1];
      end
    end
  end

  assign m_axis_tvalid = valid[7];
  assign m_axis_tdata  = {color_pipe[7].red, color_pipe[7].green, color_pipe[7].blue,
                          z_pipe[7], point_y, point_x};

endmodule

`default_nettype wire

FILE: design/dpb_checker.sv
// Port-level checks for the back-projection pipeline and their binding to the top level.
`default_nettype none

module dpb_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [dpb_pkg::OUT_W-1:0]  m_axis_tdata
);
  import dpb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Output transfer changed while stalled.");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("Output valid right after reset.");

  a_z_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[127:96] != 32'd0))
    else $error("Point with zero depth was sent.");

  a_xy_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[47:44] == 4'h0) || (m_axis_tdata[47:44] == 4'hF)) &&
                      ((m_axis_tdata[95:92] == 4'h0) || (m_axis_tdata[95:92] == 4'hF)))
    else $error("Point coordinate outside its possible range.");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
